>>> rtl/core/fpc_pkg.sv
// Shared constants and types for the six-plane frustum cull.
package fpc_pkg;

  localparam int NUM_PLANES      = 6;
  localparam int PLANE_WIDTH     = 64;
  localparam int N_WIDTH         = 16;
  localparam int D_WIDTH         = 16;
  localparam int RADIUS_WIDTH    = 15;
  localparam int ACTION_WIDTH    = 2;
  localparam int CFG_INDEX_WIDTH = 3;
  // Q8.8 distance/radius shifted up to the 22 fraction bits of n*p
  localparam int FRAC_ALIGN      = 14;

  localparam logic [ACTION_WIDTH-1:0] ACT_POINT  = 2'd0;
  localparam logic [ACTION_WIDTH-1:0] ACT_SPHERE = 2'd1;
  localparam logic [ACTION_WIDTH-1:0] ACT_POLY   = 2'd2;

  typedef logic [PLANE_WIDTH-1:0] plane_t;

  typedef struct packed {
    logic                    valid;
    logic [ACTION_WIDTH-1:0] action;
    logic                    last;
    logic [RADIUS_WIDTH-1:0] radius;
  } stage_ctl_t;

endpackage

>>> rtl/core/fpc_ifs.sv
// Handshake interfaces: geometry items, cull results and plane writes.
interface fpc_item_if #(
  parameter int COORD_WIDTH = 16
);
  logic                                 valid;
  logic                                 ready;
  logic [fpc_pkg::ACTION_WIDTH-1:0]     action;
  logic signed [COORD_WIDTH-1:0]        pos_x;
  logic signed [COORD_WIDTH-1:0]        pos_y;
  logic signed [COORD_WIDTH-1:0]        pos_z;
  logic [fpc_pkg::RADIUS_WIDTH-1:0]     radius;
  logic                                 last_vertex;

  modport source (output valid, action, pos_x, pos_y, pos_z, radius, last_vertex,
                  input ready);
  modport sink   (input valid, action, pos_x, pos_y, pos_z, radius, last_vertex,
                  output ready);
endinterface

interface fpc_result_if;
  logic                             valid;
  logic                             ready;
  logic                             visible;
  logic [fpc_pkg::ACTION_WIDTH-1:0] kind;

  modport source (output valid, visible, kind, input ready);
  modport sink   (input valid, visible, kind, output ready);
endinterface

interface fpc_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [fpc_pkg::CFG_INDEX_WIDTH-1:0] index;
  logic [fpc_pkg::PLANE_WIDTH-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/fpc_plane_regs.sv
// Six plane registers loaded through the configuration channel.
module fpc_plane_regs (
  input  logic             clk,
  input  logic             rst,
  fpc_cfg_if.sink          cfg,
  output fpc_pkg::plane_t  planes [fpc_pkg::NUM_PLANES]
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < fpc_pkg::NUM_PLANES; k++) begin
        planes[k] <= '0;
      end
    end else if (cfg.valid &&
                 cfg.index < fpc_pkg::CFG_INDEX_WIDTH'(fpc_pkg::NUM_PLANES)) begin
      planes[cfg.index] <= cfg.data;
    end
  end

endmodule

>>> rtl/core/fpc_mul_stage.sv
// Input register and registered normal-by-coordinate products for all planes.
module fpc_mul_stage #(
  parameter  int COORD_WIDTH = 16,
  localparam int PROD_WIDTH  = COORD_WIDTH + fpc_pkg::N_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  fpc_item_if.sink                       item,
  input  fpc_pkg::plane_t                planes [fpc_pkg::NUM_PLANES],
  input  logic                           advance,
  output fpc_pkg::stage_ctl_t            ctl,
  output logic signed [PROD_WIDTH-1:0]   prod_x [fpc_pkg::NUM_PLANES],
  output logic signed [PROD_WIDTH-1:0]   prod_y [fpc_pkg::NUM_PLANES],
  output logic signed [PROD_WIDTH-1:0]   prod_z [fpc_pkg::NUM_PLANES]
);

  logic                                 s1_valid;
  logic [fpc_pkg::ACTION_WIDTH-1:0]     s1_action;
  logic signed [COORD_WIDTH-1:0]        s1_x;
  logic signed [COORD_WIDTH-1:0]        s1_y;
  logic signed [COORD_WIDTH-1:0]        s1_z;
  logic [fpc_pkg::RADIUS_WIDTH-1:0]     s1_radius;
  logic                                 s1_last;

  logic                                 s2_valid;
  logic [fpc_pkg::ACTION_WIDTH-1:0]     s2_action;
  logic                                 s2_last;
  logic [fpc_pkg::RADIUS_WIDTH-1:0]     s2_radius;

  logic s1_take;
  logic s2_take;
  logic action_ok;

  assign s2_take    = !s2_valid || advance;
  assign s1_take    = !s1_valid || s2_take;
  assign item.ready = s1_take;

  // the unused action code is taken and dropped here
  assign action_ok = item.action == fpc_pkg::ACT_POINT ||
                     item.action == fpc_pkg::ACT_SPHERE ||
                     item.action == fpc_pkg::ACT_POLY;

  assign ctl = '{valid: s2_valid, action: s2_action, last: s2_last, radius: s2_radius};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_take) begin
        s1_valid <= item.valid && action_ok;
      end
      if (s2_take) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && item.valid) begin
      s1_action <= item.action;
      s1_x      <= item.pos_x;
      s1_y      <= item.pos_y;
      s1_z      <= item.pos_z;
      s1_radius <= item.radius;
      s1_last   <= item.last_vertex;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_take && s1_valid) begin
      s2_action <= s1_action;
      s2_last   <= s1_last;
      s2_radius <= s1_radius;
      for (int k = 0; k < fpc_pkg::NUM_PLANES; k++) begin
        prod_x[k] <= PROD_WIDTH'(signed'(planes[k][15:0])  * s1_x);
        prod_y[k] <= PROD_WIDTH'(signed'(planes[k][31:16]) * s1_y);
        prod_z[k] <= PROD_WIDTH'(signed'(planes[k][47:32]) * s1_z);
      end
    end
  end

endmodule

>>> rtl/core/fpc_cmp_stage.sv
// Plane sums, threshold compare, polygon tracking and the result register.
module fpc_cmp_stage #(
  parameter  int COORD_WIDTH = 16,
  localparam int PROD_WIDTH  = COORD_WIDTH + fpc_pkg::N_WIDTH,
  localparam int BASE_WIDTH  = (PROD_WIDTH > 30) ? PROD_WIDTH : 30,
  localparam int SUM_WIDTH   = BASE_WIDTH + 2
) (
  input  logic                           clk,
  input  logic                           rst,
  input  fpc_pkg::plane_t                planes [fpc_pkg::NUM_PLANES],
  input  fpc_pkg::stage_ctl_t            ctl,
  input  logic signed [PROD_WIDTH-1:0]   prod_x [fpc_pkg::NUM_PLANES],
  input  logic signed [PROD_WIDTH-1:0]   prod_y [fpc_pkg::NUM_PLANES],
  input  logic signed [PROD_WIDTH-1:0]   prod_z [fpc_pkg::NUM_PLANES],
  output logic                           advance,
  fpc_result_if.source                   result
);

  logic                               polygon_any_inside;
  logic [fpc_pkg::NUM_PLANES-1:0]     pass;
  logic signed [SUM_WIDTH-1:0]        thresh;
  logic signed [SUM_WIDTH-1:0]        rad_ext;
  logic                               all_pass;
  logic                               poly_any;
  logic                               is_poly;
  logic                               emit;
  logic                               vis;

  assign advance = !result.valid || result.ready;

  always_comb begin
    logic signed [fpc_pkg::D_WIDTH-1:0] dk;
    logic signed [SUM_WIDTH-1:0]        sum;
    rad_ext = SUM_WIDTH'(ctl.radius);
    thresh  = (ctl.action == fpc_pkg::ACT_SPHERE) ?
              -(rad_ext <<< fpc_pkg::FRAC_ALIGN) : '0;
    for (int k = 0; k < fpc_pkg::NUM_PLANES; k++) begin
      dk  = signed'(planes[k][63:48]);
      sum = SUM_WIDTH'(prod_x[k]) + SUM_WIDTH'(prod_y[k]) + SUM_WIDTH'(prod_z[k]) +
            (SUM_WIDTH'(dk) <<< fpc_pkg::FRAC_ALIGN);
      pass[k] = sum > thresh;
    end
  end

  assign all_pass = &pass;
  assign is_poly  = ctl.action == fpc_pkg::ACT_POLY;
  assign poly_any = polygon_any_inside | all_pass;
  // a polygon vertex reports only when it closes the run
  assign emit     = ctl.valid && (!is_poly || ctl.last);
  assign vis      = is_poly ? poly_any : all_pass;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid       <= 1'b0;
      polygon_any_inside <= 1'b0;
    end else if (advance) begin
      result.valid <= emit;
      if (ctl.valid && is_poly) begin
        polygon_any_inside <= ctl.last ? 1'b0 : poly_any;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      result.visible <= vis;
      result.kind    <= ctl.action;
    end
  end

endmodule

>>> rtl/core/frustum_plane_cull.sv
// Six-plane frustum cull: point, sphere and polygon visibility tests.
// An accepted beat passes through the input register, the product register and the result register.
// Throughput: one item per cycle while the result side takes results; the 18 product multipliers sit in one stage.
// Polygon vertices that are not last, and the unused action code, give no result.
// Reset (synchronous, rst high) clears all planes to zero, the polygon flag
// and every stage valid; configuration writes are taken every cycle.
module frustum_plane_cull #(
  parameter int COORD_WIDTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  fpc_item_if.sink      item,
  fpc_result_if.source  result,
  fpc_cfg_if.sink       cfg
);

  localparam int PROD_WIDTH = COORD_WIDTH + fpc_pkg::N_WIDTH;

  fpc_pkg::plane_t             planes [fpc_pkg::NUM_PLANES];
  fpc_pkg::stage_ctl_t         ctl;
  logic                        advance;
  logic signed [PROD_WIDTH-1:0] prod_x [fpc_pkg::NUM_PLANES];
  logic signed [PROD_WIDTH-1:0] prod_y [fpc_pkg::NUM_PLANES];
  logic signed [PROD_WIDTH-1:0] prod_z [fpc_pkg::NUM_PLANES];

  fpc_plane_regs u_planes (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .planes (planes)
  );

  fpc_mul_stage #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .planes  (planes),
    .advance (advance),
    .ctl     (ctl),
    .prod_x  (prod_x),
    .prod_y  (prod_y),
    .prod_z  (prod_z)
  );

  fpc_cmp_stage #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_cmp (
    .clk     (clk),
    .rst     (rst),
    .planes  (planes),
    .ctl     (ctl),
    .prod_x  (prod_x),
    .prod_y  (prod_y),
    .prod_z  (prod_z),
    .advance (advance),
    .result  (result)
  );

endmodule

>>> tb/tb.sv
// Self-checking testbench for frustum_plane_cull: plane loads, point/sphere/polygon beats.
`timescale 1ns / 1ps

module tb;
  import fpc_pkg::*;

  localparam int COORD_WIDTH   = 16;
  localparam int C_MIN         = -32768;
  localparam int C_MAX         = 32767;
  localparam int R_MAX         = 32767;
  localparam int ONE_N         = 16384;   // 1.0 in Q1.14
  localparam int HALF          = 2560;    // 10.0 in Q8.8
  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES   = 200;

  localparam logic [ACTION_WIDTH-1:0] ACT_UNUSED = 2'd3;

  localparam int REG_RIGHT  = 0;
  localparam int REG_LEFT   = 1;
  localparam int REG_BOTTOM = 2;
  localparam int REG_TOP    = 3;
  localparam int REG_FAR    = 4;
  localparam int REG_NEAR   = 5;

  typedef struct packed {
    logic [ACTION_WIDTH-1:0]       action;
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic signed [COORD_WIDTH-1:0] pos_z;
    logic [RADIUS_WIDTH-1:0]       radius;
    logic                          last;
  } geo_item_t;

  typedef struct packed {
    logic                    visible;
    logic [ACTION_WIDTH-1:0] kind;
  } verdict_t;

  // typed rows carry their own expectation; the rest go through the predictor
  typedef struct packed {
    geo_item_t beat;
    logic      typed;
    logic      gives_result;
    logic      visible;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;

  fpc_item_if #(.COORD_WIDTH(COORD_WIDTH)) geo_bus ();
  fpc_result_if                            verdict_bus ();
  fpc_cfg_if                               plane_bus ();

  frustum_plane_cull #(.COORD_WIDTH(COORD_WIDTH)) i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (geo_bus),
    .result (verdict_bus),
    .cfg    (plane_bus)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  plane_t   plane_model [NUM_PLANES];
  logic     poly_hit;
  verdict_t verdicts_due [$];
  int       mismatches;
  int       tx_idle_pct;
  int       rx_stall_pct;
  bit       hold_arm;
  int       hold_left;
  dir_row_t reset_rows [8];
  dir_row_t cube_rows [17];

  function automatic bit inside_all_planes(geo_item_t g, longint floor_v);
    longint x, y, z, s;
    plane_t pl;
    x = longint'($signed(g.pos_x));
    y = longint'($signed(g.pos_y));
    z = longint'($signed(g.pos_z));
    foreach (plane_model[k]) begin
      pl = plane_model[k];
      s = longint'($signed(pl[15:0])) * x + longint'($signed(pl[31:16])) * y
        + longint'($signed(pl[47:32])) * z + (longint'($signed(pl[63:48])) <<< FRAC_ALIGN);
      if (s <= floor_v) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Returns 1 when the beat yields a result; updates the polygon flag.
  function automatic bit cull_verdict(geo_item_t g, output verdict_t v);
    v.kind    = g.action;
    v.visible = 1'b0;
    case (g.action)
      ACT_POINT: begin
        v.visible = inside_all_planes(g, 0);
        return 1'b1;
      end
      ACT_SPHERE: begin
        v.visible = inside_all_planes(g, -(longint'(g.radius) <<< FRAC_ALIGN));
        return 1'b1;
      end
      ACT_POLY: begin
        if (inside_all_planes(g, 0)) poly_hit = 1'b1;
        if (!g.last) return 1'b0;
        v.visible = poly_hit;
        poly_hit  = 1'b0;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic geo_item_t geo(logic [ACTION_WIDTH-1:0] act, int x, int y, int z, int r,
                                    int last);
    geo_item_t g;
    g.action = act;
    g.pos_x  = x[COORD_WIDTH-1:0];
    g.pos_y  = y[COORD_WIDTH-1:0];
    g.pos_z  = z[COORD_WIDTH-1:0];
    g.radius = r[RADIUS_WIDTH-1:0];
    g.last   = last[0];
    return g;
  endfunction

  function automatic logic signed [COORD_WIDTH-1:0] rand_coord(int span);
    int v;
    if ($urandom_range(7) == 0) return COORD_WIDTH'($urandom);
    v = int'($urandom_range(2 * span)) - span;
    if (v > C_MAX) v = C_MAX;
    if (v < C_MIN) v = C_MIN;
    return v[COORD_WIDTH-1:0];
  endfunction

  function automatic geo_item_t rand_beat(logic [ACTION_WIDTH-1:0] act, int span, bit last);
    int rspan;
    rspan = (span > R_MAX) ? R_MAX : span;
    return geo(act, int'(rand_coord(span)), int'(rand_coord(span)), int'(rand_coord(span)),
               ($urandom_range(3) == 0) ? int'($urandom_range(R_MAX)) :
                                          int'($urandom_range(rspan)),
               int'(last));
  endfunction

  task automatic send_geometry(geo_item_t g, bit typed, bit t_res, bit t_vis);
    int       gap;
    bit       has;
    verdict_t v;
    gap = 0;
    while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      geo_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    geo_bus.valid       <= 1'b1;
    geo_bus.action      <= g.action;
    geo_bus.pos_x       <= g.pos_x;
    geo_bus.pos_y       <= g.pos_y;
    geo_bus.pos_z       <= g.pos_z;
    geo_bus.radius      <= g.radius;
    geo_bus.last_vertex <= g.last;
    @(posedge clk);
    while (!geo_bus.ready) @(posedge clk);
    has = cull_verdict(g, v);
    if (typed) begin
      has       = t_res;
      v.visible = t_vis;
      v.kind    = g.action;
    end
    if (has) verdicts_due.push_back(v);
  endtask

  task automatic write_plane(int idx, plane_t val);
    plane_bus.valid <= 1'b1;
    plane_bus.index <= idx[CFG_INDEX_WIDTH-1:0];
    plane_bus.data  <= val;
    @(posedge clk);
    while (!plane_bus.ready) @(posedge clk);
    if (idx < NUM_PLANES) plane_model[idx] = val;
    plane_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Park the sender and let every outstanding result drain.
  task automatic settle();
    geo_bus.valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Axis-aligned box of the given half size, or tilted planes around it.
  task automatic load_frustum(int half, bit tilted);
    for (int k = 0; k < NUM_PLANES; k++) begin
      int sgn;
      int plane_d;
      int comp [3];
      sgn = (k == REG_RIGHT || k == REG_TOP || k == REG_FAR) ? -1 : 1;
      for (int a = 0; a < 3; a++) comp[a] = tilted ? int'($urandom_range(8192)) - 4096 : 0;
      comp[k / 2] = sgn * (tilted ? int'($urandom_range(ONE_N, 8192)) : ONE_N);
      plane_d = tilted ? int'($urandom_range(half, 256)) : half;
      write_plane(k, {plane_d[15:0], comp[2][15:0], comp[1][15:0], comp[0][15:0]});
    end
  endtask

  // Mostly polygon runs; some interleaved beats, dropped last flags and unused codes.
  task automatic run_random(int count, int span);
    int sent, len, pick;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        len = $urandom_range(4, 1);
        for (int v = 0; v < len; v++) begin
          if ($urandom_range(9) == 0) begin
            send_geometry(rand_beat(ACTION_WIDTH'($urandom_range(3)), span,
                                    1'($urandom_range(1))), 1'b0, 1'b0, 1'b0);
            sent++;
          end
          send_geometry(rand_beat(ACT_POLY, span, v == len - 1 && $urandom_range(19) != 0),
                        1'b0, 1'b0, 1'b0);
        end
        sent += len;
      end else if (pick < 72) begin
        send_geometry(rand_beat(ACT_POINT, span, 1'($urandom_range(1))), 1'b0, 1'b0, 1'b0);
        sent++;
      end else if (pick < 97) begin
        send_geometry(rand_beat(ACT_SPHERE, span, 1'($urandom_range(1))), 1'b0, 1'b0, 1'b0);
        sent++;
      end else begin
        send_geometry(rand_beat(ACT_UNUSED, span, 1'($urandom_range(1))), 1'b0, 1'b0, 1'b0);
        sent++;
      end
    end
  endtask

  // Result side: random back-pressure, one long hold on request, beat checking.
  always @(posedge clk) begin
    if (rst) begin
      verdict_bus.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (verdict_bus.valid && verdict_bus.ready) begin
        if (verdicts_due.size() == 0) begin
          $display("%0t: unexpected beat, expected none, got visible %0b kind %0d",
                   $time, verdict_bus.visible, verdict_bus.kind);
          mismatches++;
        end else begin
          if (verdict_bus.visible !== verdicts_due[0].visible) begin
            $display("%0t: visible expected %0b got %0b",
                     $time, verdicts_due[0].visible, verdict_bus.visible);
            mismatches++;
          end
          if (verdict_bus.kind !== verdicts_due[0].kind) begin
            $display("%0t: kind expected %0d got %0d",
                     $time, verdicts_due[0].kind, verdict_bus.kind);
            mismatches++;
          end
          void'(verdicts_due.pop_front());
        end
      end
      if (hold_arm) begin
        hold_arm  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        verdict_bus.ready <= 1'b0;
      end else begin
        verdict_bus.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("tb: errors");
    $finish;
  end

  initial begin
    rst                 = 1'b1;
    geo_bus.valid       = 1'b0;
    geo_bus.action      = ACT_POINT;
    geo_bus.pos_x       = '0;
    geo_bus.pos_y       = '0;
    geo_bus.pos_z       = '0;
    geo_bus.radius      = '0;
    geo_bus.last_vertex = 1'b0;
    verdict_bus.ready   = 1'b0;
    plane_bus.valid     = 1'b0;
    plane_bus.index     = '0;
    plane_bus.data      = '0;
    tx_idle_pct         = 0;
    rx_stall_pct        = 0;
    hold_arm            = 1'b0;
    mismatches          = 0;
    poly_hit            = 1'b0;
    foreach (plane_model[k]) plane_model[k] = '0;

    // all planes zero: every sum is 0
    reset_rows = '{
      '{geo(ACT_POINT,  0, 0, 0, 0, 0),                 1'b1, 1'b1, 1'b0},
      '{geo(ACT_SPHERE, 0, 0, 0, 0, 0),                 1'b1, 1'b1, 1'b0},
      '{geo(ACT_SPHERE, 0, 0, 0, 1, 1),                 1'b1, 1'b1, 1'b1},
      '{geo(ACT_SPHERE, C_MAX, C_MAX, C_MAX, R_MAX, 0), 1'b1, 1'b1, 1'b1},
      '{geo(ACT_POLY,   C_MIN, C_MIN, C_MIN, R_MAX, 0), 1'b1, 1'b0, 1'b0},
      '{geo(ACT_UNUSED, C_MAX, C_MIN, C_MAX, R_MAX, 1), 1'b1, 1'b0, 1'b0},
      '{geo(ACT_POLY,   0, 0, 0, 0, 1),                 1'b1, 1'b1, 1'b0},
      '{geo(ACT_POINT,  C_MAX, C_MAX, C_MAX, R_MAX, 1), 1'b1, 1'b1, 1'b0}
    };

    // box of half size 10.0: boundaries, touching spheres, polygon runs
    cube_rows = '{
      '{geo(ACT_POINT,  0, 0, 0, 0, 0),                 1'b1, 1'b1, 1'b1},
      '{geo(ACT_POINT,  HALF, 0, 0, 0, 0),              1'b1, 1'b1, 1'b0},
      '{geo(ACT_POINT,  HALF - 1, 0, 0, 0, 0),          1'b0, 1'b0, 1'b0},
      '{geo(ACT_POINT,  0, -HALF, 0, 0, 0),             1'b0, 1'b0, 1'b0},
      '{geo(ACT_SPHERE, 0, 0, 3072, 512, 0),            1'b0, 1'b0, 1'b0},
      '{geo(ACT_SPHERE, 0, 0, 3072, 513, 0),            1'b0, 1'b0, 1'b0},
      '{geo(ACT_SPHERE, C_MIN, C_MIN, C_MIN, R_MAX, 1), 1'b0, 1'b0, 1'b0},
      '{geo(ACT_POLY,   5120, 0, 0, 0, 0),              1'b0, 1'b0, 1'b0},
      '{geo(ACT_POLY,   0, 0, 0, 0, 0),                 1'b0, 1'b0, 1'b0},
      '{geo(ACT_POINT,  7680, 0, 0, 0, 1),              1'b0, 1'b0, 1'b0},
      '{geo(ACT_UNUSED, 0, 0, 0, 0, 1),                 1'b1, 1'b0, 1'b0},
      '{geo(ACT_POLY,   5120, 5120, 5120, 0, 1),        1'b0, 1'b0, 1'b0},
      '{geo(ACT_POLY,   5120, 0, 0, 0, 0),              1'b0, 1'b0, 1'b0},
      '{geo(ACT_POLY,   0, 7680, 0, 0, 1),              1'b0, 1'b0, 1'b0},
      '{geo(ACT_POLY,   0, 0, 0, 0, 1),                 1'b0, 1'b0, 1'b0},
      '{geo(ACT_POLY,   C_MAX, C_MAX, C_MAX, 0, 0),     1'b0, 1'b0, 1'b0},
      '{geo(ACT_POLY,   C_MIN, C_MIN, C_MIN, 0, 1),     1'b0, 1'b0, 1'b0}
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (reset_rows[i])
      send_geometry(reset_rows[i].beat, reset_rows[i].typed,
                    reset_rows[i].gives_result, reset_rows[i].visible);
    settle();

    load_frustum(HALF, 1'b0);
    for (int i = NUM_PLANES; i < 2 ** CFG_INDEX_WIDTH; i++) write_plane(i, '1);
    foreach (cube_rows[i])
      send_geometry(cube_rows[i].beat, cube_rows[i].typed,
                    cube_rows[i].gives_result, cube_rows[i].visible);
    settle();

    // back to back, small box
    run_random(160, 3 * HALF);
    settle();

    // tilted planes, sparse input
    tx_idle_pct = 61;
    load_frustum($urandom_range(8192, 1024), 1'b1);
    run_random(160, 12000);
    settle();

    // heavy back-pressure plus one long hold while beats keep coming
    tx_idle_pct  = 0;
    rx_stall_pct = 61;
    load_frustum(16384, 1'b0);
    hold_arm = 1'b1;
    run_random(160, C_MAX);
    settle();

    // extreme plane words
    tx_idle_pct  = 7;
    rx_stall_pct = 7;
    write_plane(REG_RIGHT,  {16'h7FFF, 48'h0});
    write_plane(REG_LEFT,   64'h8000_8000_8000_8000);
    write_plane(REG_BOTTOM, '1);
    write_plane(REG_TOP,    64'h7FFF_7FFF_7FFF_7FFF);
    write_plane(REG_FAR,    '0);
    write_plane(REG_NEAR,   {16'h8000, 16'h0, 16'h0, 16'h4000});
    run_random(80, C_MAX);
    settle();

    // tiny tilted frustum, no idling
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    load_frustum(256, 1'b1);
    run_random(140, 1024);
    settle();

    if (mismatches == 0) $display("tb: clean");
    else                 $display("tb: errors");
    $finish;
  end

endmodule
